### sv/tcc_pkg.sv
package tcc_pkg;

	// Bytes per character cell in the frame buffer (character byte and attribute byte).
	localparam int CELL_BYTES = 2;

	// Request kinds.
	localparam logic [1:0] REQ_PUT   = 2'd0;
	localparam logic [1:0] REQ_SET   = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;

	// Control characters.
	localparam logic [7:0] CH_BACKSPACE = 8'd8;
	localparam logic [7:0] CH_TAB       = 8'd9;
	localparam logic [7:0] CH_NEWLINE   = 8'd10;
	localparam logic [8:0] TAB_STEP     = 9'd4;

	// Configuration register indexes.
	localparam logic [1:0] CFG_COLUMNS = 2'd0;
	localparam logic [1:0] CFG_ROWS    = 2'd1;
	localparam logic [1:0] CFG_ATTR    = 2'd2;

	// Reset values of the configuration registers.
	localparam logic [7:0] COLUMNS_RST = 8'd80;
	localparam logic [7:0] ROWS_RST    = 8'd25;
	localparam logic [7:0] ATTR_RST    = 8'd15;

	// Smallest usable geometry.
	localparam logic [7:0] MIN_COLUMNS = 8'd4;
	localparam logic [7:0] MIN_ROWS    = 8'd1;

	typedef struct packed {
		logic [7:0] row_in;
		logic [7:0] col_in;
		logic [7:0] char_code;
		logic [1:0] req_type;
	} item_t;

	typedef struct packed {
		logic [15:0] cursor_pos;
		logic        screen_clear;
		logic [7:0]  cell_attr;
		logic [7:0]  cell_char;
		logic [16:0] cell_byte_addr;
		logic        cell_write;
	} result_t;

	// Effective screen geometry and attribute.
	typedef struct packed {
		logic [7:0] ncol;
		logic [7:0] nrow;
		logic [7:0] attr;
	} geom_t;

endpackage

### sv/tcc_cfg.sv
module tcc_cfg
	import tcc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	output geom_t      geom
);

	logic [7:0] columns_q;
	logic [7:0] rows_q;
	logic [7:0] attr_q;

	// Register writes; an index past the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			columns_q <= COLUMNS_RST;
			rows_q    <= ROWS_RST;
			attr_q    <= ATTR_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_COLUMNS: columns_q <= cfg_data;
				CFG_ROWS:    rows_q    <= cfg_data;
				CFG_ATTR:    attr_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Geometry below the minimum is used at the minimum.
	assign geom.ncol = (columns_q < MIN_COLUMNS) ? MIN_COLUMNS : columns_q;
	assign geom.nrow = (rows_q == 8'd0) ? MIN_ROWS : rows_q;
	assign geom.attr = attr_q;

endmodule

### sv/tcc_step.sv
module tcc_step
	import tcc_pkg::*;
(
	input  item_t      item,
	input  geom_t      geom,
	input  logic [7:0] cur_col,
	input  logic [7:0] cur_row,
	output logic [7:0] next_col,
	output logic [7:0] next_row,
	output result_t    res
);

	logic [8:0]  col_w;
	logic [8:0]  row_w;
	logic [7:0]  wr_col;
	logic        wr;
	logic [7:0]  wch;
	logic        clr;
	logic        on_screen;
	logic [15:0] wr_lin;
	logic [15:0] pos_lin;

	assign on_screen = (cur_col < geom.ncol) && (cur_row < geom.nrow);

	// Cursor movement and cell write for one request.
	always_comb begin
		next_col = cur_col;
		next_row = cur_row;
		col_w    = {1'b0, cur_col};
		row_w    = {1'b0, cur_row};
		wr_col   = cur_col;
		wr       = 1'b0;
		wch      = 8'd0;
		clr      = 1'b0;
		unique case (item.req_type)
			REQ_SET: begin
				next_col = (item.col_in >= geom.ncol) ? geom.ncol - 8'd1 : item.col_in;
				next_row = (item.row_in >= geom.nrow) ? geom.nrow - 8'd1 : item.row_in;
			end
			REQ_CLEAR: begin
				next_col = 8'd0;
				next_row = 8'd0;
				clr      = 1'b1;
			end
			REQ_PUT: begin
				if (on_screen) begin
					unique case (item.char_code)
						CH_NEWLINE: begin
							col_w = 9'd0;
							row_w = row_w + 9'd1;
						end
						CH_BACKSPACE: begin
							// At the origin backspace leaves everything alone.
							if (cur_col != 8'd0) begin
								col_w  = col_w - 9'd1;
								wr_col = cur_col - 8'd1;
								wr     = 1'b1;
							end else if (cur_row != 8'd0) begin
								col_w = {1'b0, geom.ncol} - 9'd1;
								row_w = row_w - 9'd1;
							end
						end
						CH_TAB: begin
							col_w = col_w + TAB_STEP;
						end
						default: begin
							wr    = 1'b1;
							wch   = item.char_code;
							col_w = col_w + 9'd1;
						end
					endcase
					// Column overflow wraps into the next row.
					if (col_w >= {1'b0, geom.ncol}) begin
						col_w = col_w - {1'b0, geom.ncol};
						row_w = row_w + 9'd1;
					end
					// Running off the bottom clears the screen and homes the cursor.
					if (row_w >= {1'b0, geom.nrow}) begin
						col_w = 9'd0;
						row_w = 9'd0;
						clr   = 1'b1;
					end
					next_col = col_w[7:0];
					next_row = row_w[7:0];
				end
			end
			default: ;
		endcase
	end

	// Linear cell index of the write and of the new cursor.
	assign wr_lin  = ({8'd0, cur_row} * {8'd0, geom.ncol}) + {8'd0, wr_col};
	assign pos_lin = ({8'd0, next_row} * {8'd0, geom.ncol}) + {8'd0, next_col};

	assign res.cell_write     = wr;
	assign res.cell_byte_addr = wr ? 17'(wr_lin * CELL_BYTES) : 17'd0;
	assign res.cell_char      = wch;
	assign res.cell_attr      = wr ? geom.attr : 8'd0;
	assign res.screen_clear   = clr;
	assign res.cursor_pos     = pos_lin;

endmodule

### sv/text_console_cursor_engine.sv
// Text console cursor engine: takes one request per clock (put character, set cursor,
// clear screen) and returns exactly one result per request, holding a cell write,
// a clear flag and the new linear cursor position. Throughput is one transaction per
// cycle while the result side is not stalled. An accepted request is held in the input
// register, and its result is loaded into the result register once that register is
// free or being drained. One transaction per cycle is possible because the cursor
// update (compares, an add and a subtract on 8-bit values) is combinational between
// the input register and the cursor registers; the 8x8 multiply for the addresses lies
// only on the result path. A stalled result side holds both registers, and the input
// side stalls once both are full. Write the configuration registers only while no
// request is in flight.
module text_console_cursor_engine
	import tcc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // req_type, char_code, col_in, row_in, zero pad
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata   // cell_write, cell_byte_addr, cell_char,
	                                   // cell_attr, screen_clear, cursor_pos, zero pad
);

	geom_t      geom;
	item_t      item_s1;
	logic       valid_s1;
	result_t    res;
	result_t    res_q;
	logic       out_valid_q;
	logic [7:0] col_q;
	logic [7:0] row_q;
	logic [7:0] next_col;
	logic [7:0] next_row;
	logic       advance;

	tcc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.geom      (geom)
	);

	tcc_step u_step (
		.item     (item_s1),
		.geom     (geom),
		.cur_col  (col_q),
		.cur_row  (row_q),
		.next_col (next_col),
		.next_row (next_row),
		.res      (res)
	);

	// The held item moves on when the result register is free or being drained.
	assign advance       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1 <= item_t'(s_axis_tdata[25:0]);
		end
	end

	// Cursor state and result register update together when an item is processed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= 8'd0;
			row_q       <= 8'd0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				col_q <= next_col;
				row_q <= next_row;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'd0, res_q};

endmodule
